// ===== hdl/sbmc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbmc_pkg
// shared types and codes of the spectral bin magnitude clamp
// ----------------------------------------------------------------------------
package sbmc_pkg;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_UP   = 2'd2
  } clamp_kind_t;

endpackage

// ===== hdl/sbmc_sqrt.sv =====
// ----------------------------------------------------------------------------
// sbmc_sqrt
// two-lane pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sbmc_sqrt #(
  parameter int W      = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-1:0]    in_x0,
  input  logic [2*W-1:0]    in_x1,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W-1:0]      out_root0,
  output logic [W-1:0]      out_root1,
  output logic [SIDE_W-1:0] out_side
);

  logic [2*W-1:0]    x_r    [1:W][2];
  logic [W+1:0]      rem_r  [1:W][2];
  logic [W-1:0]      root_r [1:W][2];
  logic              v_r    [1:W];
  logic [SIDE_W-1:0] side_r [1:W];

  genvar s, l;
  generate
    for (s = 0; s < W; s++) begin : g_stage
      logic              v_cur;
      logic [SIDE_W-1:0] side_cur;

      if (s == 0) begin : g_first
        assign v_cur    = in_valid;
        assign side_cur = in_side;
      end else begin : g_next
        assign v_cur    = v_r[s];
        assign side_cur = side_r[s];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s+1] <= 1'b0;
        end else if (en) begin
          v_r[s+1] <= v_cur;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side_r[s+1] <= side_cur;
        end
      end

      for (l = 0; l < 2; l++) begin : g_lane
        logic [2*W-1:0] x_cur;
        logic [W+1:0]   rem_cur;
        logic [W-1:0]   root_cur;
        logic [W+1:0]   sh;
        logic [W+1:0]   trial;
        logic           ge;

        if (s == 0) begin : g_first
          assign x_cur    = (l == 0) ? in_x0 : in_x1;
          assign rem_cur  = '0;
          assign root_cur = '0;
        end else begin : g_next
          assign x_cur    = x_r[s][l];
          assign rem_cur  = rem_r[s][l];
          assign root_cur = root_r[s][l];
        end

        assign sh    = {rem_cur[W-1:0], x_cur[2*W-1 -: 2]};
        assign trial = {root_cur, 2'b01};
        assign ge    = (sh >= trial);

        always_ff @(posedge clk) begin
          if (en) begin
            x_r[s+1][l]    <= {x_cur[2*W-3:0], 2'b00};
            rem_r[s+1][l]  <= ge ? (sh - trial) : sh;
            root_r[s+1][l] <= {root_cur[W-2:0], ge};
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_r[W];
  assign out_root0 = root_r[W][0];
  assign out_root1 = root_r[W][1];
  assign out_side  = side_r[W];

endmodule

// ===== hdl/sbmc_div.sv =====
// ----------------------------------------------------------------------------
// sbmc_div
// two-lane pipelined restoring divider with shared divisor, one quotient
// bit per stage
// ----------------------------------------------------------------------------
module sbmc_div #(
  parameter int W      = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-1:0]    in_n0,
  input  logic [2*W-1:0]    in_n1,
  input  logic [W-1:0]      in_d,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [W:0]        out_q0,
  output logic [W:0]        out_q1,
  output logic [W-1:0]      out_r0,
  output logic [W-1:0]      out_r1,
  output logic [W-1:0]      out_d,
  output logic [SIDE_W-1:0] out_side
);

  localparam int Q = W + 1;

  logic [Q-1:0]      nlo_r  [1:Q][2];
  logic [W:0]        rem_r  [1:Q][2];
  logic [Q-1:0]      quo_r  [1:Q][2];
  logic [W-1:0]      d_r    [1:Q];
  logic              v_r    [1:Q];
  logic [SIDE_W-1:0] side_r [1:Q];

  genvar s, l;
  generate
    for (s = 0; s < Q; s++) begin : g_stage
      logic              v_cur;
      logic [W-1:0]      d_cur;
      logic [SIDE_W-1:0] side_cur;

      if (s == 0) begin : g_first
        assign v_cur    = in_valid;
        assign d_cur    = in_d;
        assign side_cur = in_side;
      end else begin : g_next
        assign v_cur    = v_r[s];
        assign d_cur    = d_r[s];
        assign side_cur = side_r[s];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s+1] <= 1'b0;
        end else if (en) begin
          v_r[s+1] <= v_cur;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          d_r[s+1]    <= d_cur;
          side_r[s+1] <= side_cur;
        end
      end

      for (l = 0; l < 2; l++) begin : g_lane
        logic [Q-1:0]   nlo_cur;
        logic [W:0]     rem_cur;
        logic [Q-1:0]   quo_cur;
        logic [W:0]     sh;
        logic           ge;

        if (s == 0) begin : g_first
          logic [2*W-1:0] n_in;
          assign n_in    = (l == 0) ? in_n0 : in_n1;
          assign nlo_cur = n_in[Q-1:0];
          assign rem_cur = {2'b00, n_in[2*W-1:Q]};
          assign quo_cur = '0;
        end else begin : g_next
          assign nlo_cur = nlo_r[s][l];
          assign rem_cur = rem_r[s][l];
          assign quo_cur = quo_r[s][l];
        end

        assign sh = {rem_cur[W-1:0], nlo_cur[Q-1]};
        assign ge = (sh >= {1'b0, d_cur});

        always_ff @(posedge clk) begin
          if (en) begin
            nlo_r[s+1][l] <= {nlo_cur[Q-2:0], 1'b0};
            rem_r[s+1][l] <= ge ? (sh - {1'b0, d_cur}) : sh;
            quo_r[s+1][l] <= {quo_cur[Q-2:0], ge};
          end
        end
      end
    end
  endgenerate

  assign out_valid = v_r[Q];
  assign out_q0    = quo_r[Q][0];
  assign out_q1    = quo_r[Q][1];
  assign out_r0    = rem_r[Q][0][W-1:0];
  assign out_r1    = rem_r[Q][1][W-1:0];
  assign out_d     = d_r[Q];
  assign out_side  = side_r[Q];

endmodule

// ===== hdl/spectral_bin_magnitude_clamp.sv =====
// ----------------------------------------------------------------------------
// spectral_bin_magnitude_clamp
// per-bin clamp of a perturbed spectrum to the clean magnitude +/- a limit
//
// input channel: one beat per frequency bin (clean and perturbed complex
// values plus the allowed magnitude deviation), valid/ready
// result channel: one beat per bin (rescaled or passed value and the clamp
// kind), valid/ready, driven straight from the output register
// pipeline: input register, squares, sums of squares, square root pipeline
// (one root bit per stage), decision, products, divider pipeline (one
// quotient bit per stage), output register
// throughput: one bin per cycle while out_ready is high
// stall: the whole pipeline holds while the output register is full and
// out_ready is low; in_ready drops in the same cycle, nothing is lost
// reset: synchronous, clears all stage valid bits, no clearing pass
// ----------------------------------------------------------------------------
module spectral_bin_magnitude_clamp #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_clean_real,
  input  logic [SAMPLE_WIDTH-1:0] in_clean_imag,
  input  logic [SAMPLE_WIDTH-1:0] in_pert_real,
  input  logic [SAMPLE_WIDTH-1:0] in_pert_imag,
  input  logic [SAMPLE_WIDTH-2:0] in_limit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] out_real,
  output logic [SAMPLE_WIDTH-1:0] out_imag,
  output logic [1:0]              out_clamp_kind
);

  localparam int W = SAMPLE_WIDTH;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W+1:0] HALF = {2'b00, 1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] pr;
    logic [W-1:0] pi;
    logic [W-2:0] lim;
  } sside_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [W:0]   target;
    logic [W-1:0] pr;
    logic [W-1:0] pi;
  } dside_t;

  logic en;

  // input register
  logic signed [W-1:0] a_cr_r, a_ci_r, a_pr_r, a_pi_r;
  logic [W-2:0]        a_lim_r;
  logic                a_v_r;

  // squares
  logic signed [2*W-1:0] b_sq_r [4];
  logic [W-1:0]          b_pr_r, b_pi_r;
  logic [W-2:0]          b_lim_r;
  logic                  b_v_r;

  // sums of squares
  logic [2*W-1:0] c_cs_r, c_ps_r;
  sside_t         c_side_r;
  logic           c_v_r;

  // square root outputs
  logic         s_v;
  logic [W-1:0] s_cmag, s_pmag;
  sside_t       s_side;

  // decision
  logic [W:0]   cm1, pm1, lim1, hi_bound;
  logic         down_nxt, up_nxt;
  logic [1:0]   d_kind_r;
  logic [W:0]   d_target_r;
  logic [W-1:0] d_pmag_r, d_pr_r, d_pi_r;
  logic         d_v_r;

  // products
  logic [W-1:0]   abs_pr, abs_pi;
  logic [2*W:0]   prod_r_full, prod_i_full;
  logic [2*W-1:0] e_nr_r, e_ni_r;
  logic [W-1:0]   e_pmag_r;
  dside_t         e_side_r;
  logic           e_v_r;

  // divider outputs
  logic         f_v;
  logic [W:0]   f_qr, f_qi;
  logic [W-1:0] f_rr, f_ri, f_d;
  dside_t       f_side;

  // output register
  logic [W-1:0] real_nxt, imag_nxt;
  logic         out_valid_r;
  logic [W-1:0] out_real_r, out_imag_r;
  logic [1:0]   out_kind_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= s_v;
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cr_r  <= in_clean_real;
      a_ci_r  <= in_clean_imag;
      a_pr_r  <= in_pert_real;
      a_pi_r  <= in_pert_imag;
      a_lim_r <= in_limit;

      b_sq_r[0] <= a_cr_r * a_cr_r;
      b_sq_r[1] <= a_ci_r * a_ci_r;
      b_sq_r[2] <= a_pr_r * a_pr_r;
      b_sq_r[3] <= a_pi_r * a_pi_r;
      b_pr_r    <= a_pr_r;
      b_pi_r    <= a_pi_r;
      b_lim_r   <= a_lim_r;

      c_cs_r       <= b_sq_r[0] + b_sq_r[1];
      c_ps_r       <= b_sq_r[2] + b_sq_r[3];
      c_side_r.pr  <= b_pr_r;
      c_side_r.pi  <= b_pi_r;
      c_side_r.lim <= b_lim_r;
    end
  end

  sbmc_sqrt #(
    .W      (W),
    .SIDE_W ($bits(sside_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_v_r),
    .in_x0     (c_cs_r),
    .in_x1     (c_ps_r),
    .in_side   (c_side_r),
    .out_valid (s_v),
    .out_root0 (s_cmag),
    .out_root1 (s_pmag),
    .out_side  (s_side)
  );

  assign cm1      = {1'b0, s_cmag};
  assign pm1      = {1'b0, s_pmag};
  assign lim1     = {2'b00, s_side.lim};
  assign hi_bound = cm1 + lim1;
  assign down_nxt = (pm1 > hi_bound);
  assign up_nxt   = ((pm1 + lim1) < cm1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (down_nxt) begin
        d_kind_r   <= sbmc_pkg::KIND_DOWN;
        d_target_r <= hi_bound;
      end else if (up_nxt) begin
        d_kind_r   <= sbmc_pkg::KIND_UP;
        d_target_r <= (cm1 > lim1) ? (cm1 - lim1) : '0;
      end else begin
        d_kind_r   <= sbmc_pkg::KIND_PASS;
        d_target_r <= '0;
      end
      d_pmag_r <= s_pmag;
      d_pr_r   <= s_side.pr;
      d_pi_r   <= s_side.pi;
    end
  end

  assign abs_pr      = d_pr_r[W-1] ? (~d_pr_r + 1'b1) : d_pr_r;
  assign abs_pi      = d_pi_r[W-1] ? (~d_pi_r + 1'b1) : d_pi_r;
  assign prod_r_full = d_target_r * abs_pr;
  assign prod_i_full = d_target_r * abs_pi;

  always_ff @(posedge clk) begin
    if (en) begin
      e_nr_r          <= prod_r_full[2*W-1:0];
      e_ni_r          <= prod_i_full[2*W-1:0];
      e_pmag_r        <= d_pmag_r;
      e_side_r.kind   <= d_kind_r;
      e_side_r.target <= d_target_r;
      e_side_r.pr     <= d_pr_r;
      e_side_r.pi     <= d_pi_r;
    end
  end

  sbmc_div #(
    .W      (W),
    .SIDE_W ($bits(dside_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_v_r),
    .in_n0     (e_nr_r),
    .in_n1     (e_ni_r),
    .in_d      (e_pmag_r),
    .in_side   (e_side_r),
    .out_valid (f_v),
    .out_q0    (f_qr),
    .out_q1    (f_qi),
    .out_r0    (f_rr),
    .out_r1    (f_ri),
    .out_d     (f_d),
    .out_side  (f_side)
  );

  // round half away from zero, restore sign, saturate
  function automatic logic [W-1:0] finish(input logic [W:0] q, input logic [W-1:0] r,
                                          input logic [W-1:0] d, input logic neg);
    logic [W+1:0] m;
    logic         up;
    up = ({r, 1'b0} >= {1'b0, d});
    m  = {1'b0, q} + {{(W+1){1'b0}}, up};
    if (!neg) begin
      finish = (m >= HALF) ? SMAX : m[W-1:0];
    end else begin
      finish = (m > HALF) ? SMIN : (~m[W-1:0] + 1'b1);
    end
  endfunction

  always_comb begin
    real_nxt = f_side.pr;
    imag_nxt = f_side.pi;
    if (f_side.kind != sbmc_pkg::KIND_PASS) begin
      if (f_d == '0) begin
        real_nxt = ({1'b0, f_side.target} >= HALF) ? SMAX : f_side.target[W-1:0];
        imag_nxt = '0;
      end else begin
        real_nxt = finish(f_qr, f_rr, f_d, f_side.pr[W-1]);
        imag_nxt = finish(f_qi, f_ri, f_d, f_side.pi[W-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_real_r <= real_nxt;
      out_imag_r <= imag_nxt;
      out_kind_r <= f_side.kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_real       = out_real_r;
  assign out_imag       = out_imag_r;
  assign out_clamp_kind = out_kind_r;

endmodule

// ===== hdl/sbmc_checker.sv =====
// ----------------------------------------------------------------------------
// sbmc_checker
// port-level checks of the spectral bin magnitude clamp
// ----------------------------------------------------------------------------
module sbmc_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_real,
  input logic [SAMPLE_WIDTH-1:0] out_imag,
  input logic [1:0]              out_clamp_kind
);

  // result beat held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_real) && $stable(out_imag)
                               && $stable(out_clamp_kind))
    else $error("result beat changed while stalled");

  // pipeline advances whenever the result side can take a beat
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clamp_kind == sbmc_pkg::KIND_PASS
               || out_clamp_kind == sbmc_pkg::KIND_DOWN
               || out_clamp_kind == sbmc_pkg::KIND_UP)
    else $error("illegal clamp kind");

  // no result beat in the cycle after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind spectral_bin_magnitude_clamp sbmc_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sbmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_real       (out_real),
  .out_imag       (out_imag),
  .out_clamp_kind (out_clamp_kind)
);

// ===== verif/spectral_bin_magnitude_clamp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectral_bin_magnitude_clamp_tb
// drives frequency bins through the clamp and checks every result beat
// against a bit-exact predictor (or, for some directed rows, the expected
// result in the table): a directed table of extremes and special cases,
// then random bins weighted toward the clamp thresholds, with random idling
// on both channels and one long result hold-off
module spectral_bin_magnitude_clamp_tb;

  localparam int W = 24;
  localparam longint SMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam int RAND_BINS = 1080;

  typedef struct {
    logic signed [W-1:0] cre;
    logic signed [W-1:0] cim;
    logic signed [W-1:0] pre;
    logic signed [W-1:0] pim;
    logic [W-2:0]        lim;
  } bin_t;

  typedef struct {
    logic [W-1:0]          re;
    logic [W-1:0]          im;
    sbmc_pkg::clamp_kind_t kind;
  } clamped_t;

  typedef struct {
    bin_t     b;
    bit       typed;
    clamped_t r;
  } row_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_valid = 0;
  logic         in_ready;
  logic [W-1:0] in_clean_real = '0;
  logic [W-1:0] in_clean_imag = '0;
  logic [W-1:0] in_pert_real = '0;
  logic [W-1:0] in_pert_imag = '0;
  logic [W-2:0] in_limit = '0;
  logic         out_valid;
  logic         out_ready = 0;
  logic [W-1:0] out_real;
  logic [W-1:0] out_imag;
  logic [1:0]   out_clamp_kind;

  clamped_t pending_bins[$];
  row_t     dir_rows[$];
  int       errors = 0;
  int       beats_out = 0;
  bit       sending_done = 0;

  spectral_bin_magnitude_clamp #(.SAMPLE_WIDTH(W)) uut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint mag_of(longint re, longint im);
    longint unsigned a, b;
    a = re < 0 ? -re : re;
    b = im < 0 ? -im : im;
    return longint'(isqrt(a * a + b * b));
  endfunction

  function automatic longint sat(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint scale_part(longint target, longint part, longint m);
    longint unsigned p, q, r, prod;
    p = part < 0 ? -part : part;
    prod = (target % m) * p;
    q = (target / m) * p + prod / m;
    r = prod % m;
    if (2 * r >= m) q += 1;
    return sat(part < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic clamped_t clamp_bin(bin_t b);
    clamped_t o;
    longint cmag, pmag, diff, lim, target, re, im;
    cmag = mag_of(b.cre, b.cim);
    pmag = mag_of(b.pre, b.pim);
    lim = b.lim;
    diff = pmag - cmag;
    re = b.pre;
    im = b.pim;
    o.kind = sbmc_pkg::KIND_PASS;
    target = 0;
    if (diff > lim) begin
      o.kind = sbmc_pkg::KIND_DOWN;
      target = cmag + lim;
    end else if (diff < -lim) begin
      o.kind = sbmc_pkg::KIND_UP;
      target = cmag > lim ? cmag - lim : 0;
    end
    if (o.kind != sbmc_pkg::KIND_PASS) begin
      if (pmag == 0) begin
        re = sat(target);
        im = 0;
      end else begin
        re = scale_part(target, b.pre, pmag);
        im = scale_part(target, b.pim, pmag);
      end
    end
    o.re = re[W-1:0];
    o.im = im[W-1:0];
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(longint cr, longint ci, longint pr, longint pi, longint lm,
                         bit typed, longint er, longint ei,
                         sbmc_pkg::clamp_kind_t ek);
    row_t w;
    w.b.cre = cr[W-1:0];
    w.b.cim = ci[W-1:0];
    w.b.pre = pr[W-1:0];
    w.b.pim = pi[W-1:0];
    w.b.lim = lm[W-2:0];
    w.typed = typed;
    w.r.re = er[W-1:0];
    w.r.im = ei[W-1:0];
    w.r.kind = ek;
    dir_rows.push_back(w);
  endtask

  task automatic send_bin(bin_t b, int gap, bit typed, clamped_t want);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_clean_real = b.cre;
    in_clean_imag = b.cim;
    in_pert_real = b.pre;
    in_pert_imag = b.pim;
    in_limit = b.lim;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    pending_bins.push_back(typed ? want : clamp_bin(b));
  endtask

  function automatic bin_t rand_bin();
    bin_t b;
    longint cr, ci, d, pr_v, pi_v;
    int mode;
    mode = $urandom_range(0, 9);
    cr = $signed(W'($urandom));
    ci = $signed(W'($urandom));
    if (mode < 2) begin
      b.cre = cr[W-1:0];
      b.cim = ci[W-1:0];
      b.pre = W'($urandom);
      b.pim = W'($urandom);
      b.lim = (W-1)'($urandom);
    end else begin
      if (mode < 5) begin
        cr = cr >>> $urandom_range(0, 20);
        ci = ci >>> $urandom_range(0, 20);
      end
      d = longint'($urandom_range(0, 2000)) - 1000;
      pr_v = sat(cr + d);
      pi_v = sat(ci + longint'($urandom_range(0, 2000)) - 1000);
      b.cre = cr[W-1:0];
      b.cim = ci[W-1:0];
      b.pre = pr_v[W-1:0];
      b.pim = pi_v[W-1:0];
      b.lim = (mode == 9) ? (W-1)'($urandom) : (W-1)'($urandom_range(0, 1200));
      if (mode == 8) begin
        b.pre = '0;
        b.pim = '0;
      end
    end
    return b;
  endfunction

  initial begin
    clamped_t none;
    none.re = '0;
    none.im = '0;
    none.kind = sbmc_pkg::KIND_PASS;
    add_row(0, 0, 0, 0, 0, 1, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(0, 0, SMAX, 0, 0, 1, 0, 0, sbmc_pkg::KIND_DOWN);
    add_row(SMAX, 0, 0, 0, 0, 1, SMAX, 0, sbmc_pkg::KIND_UP);
    add_row(SMIN, SMIN, 1, 0, 0, 1, SMAX, 0, sbmc_pkg::KIND_UP);
    add_row(SMIN, SMIN, -1, 0, 0, 1, SMIN, 0, sbmc_pkg::KIND_UP);
    add_row(SMIN, SMIN, 0, 0, 0, 1, SMAX, 0, sbmc_pkg::KIND_UP);
    add_row(0, 0, SMIN, SMIN, SMAX, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(SMAX, SMAX, SMIN, SMIN, SMAX, 1, SMIN, SMIN, sbmc_pkg::KIND_PASS);
    add_row(5, 0, 0, 0, 9, 1, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(100, 0, 0, 0, 40, 1, 60, 0, sbmc_pkg::KIND_UP);
    add_row(SMIN, SMIN, SMAX, -3, 100, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(SMIN, 0, 3, 4, 0, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(3, 4, 300, -400, 10, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(300, 400, -3, 4, 10, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(1000, 0, 1010, 0, 10, 1, 1010, 0, sbmc_pkg::KIND_PASS);
    add_row(1000, 0, 1011, 0, 10, 1, 1010, 0, sbmc_pkg::KIND_DOWN);
    add_row(1000, 0, 989, 0, 10, 1, 990, 0, sbmc_pkg::KIND_UP);
    add_row(1000, 0, 0, -7, 2000, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(-SMAX, 7, -5, -SMAX, 1, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(12345, -6789, -12000, 7000, SMAX, 0, 0, 0, sbmc_pkg::KIND_PASS);
    add_row(2, 2, SMAX, SMAX, 1, 0, 0, 0, sbmc_pkg::KIND_PASS);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    foreach (dir_rows[i])
      send_bin(dir_rows[i].b, i % 3 == 0 ? 0 : pick_gap(), dir_rows[i].typed, dir_rows[i].r);
    for (int i = 0; i < RAND_BINS; i++)
      send_bin(rand_bin(), (i / 150) % 3 == 0 ? 0 : pick_gap(), 0, none);
    @(negedge clk);
    in_valid = 0;
    sending_done = 1;
    wait (pending_bins.size() == 0);
    repeat (2 * W + 20) @(posedge clk);
    if (errors == 0) begin
      $display("spectral_bin_magnitude_clamp_tb passed");
    end else begin
      $display("spectral_bin_magnitude_clamp_tb failed");
    end
    $finish;
  end

  // result side idling, with one long hold-off while the sender still offers bins
  initial begin
    int gap;
    int held;
    bit hold_done;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && beats_out > 100) begin
        hold_done = 1;
        out_ready = 0;
        held = 0;
        while (held < 300) begin
          @(negedge clk);
          held++;
        end
      end
      if (((beats_out / 200) % 3) != 1 && !sending_done) begin
        gap = pick_gap();
      end else begin
        gap = 0;
      end
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
    end
  end

  always @(posedge clk) begin
    clamped_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (pending_bins.size() == 0) begin
        report("unexpected beat, kind", out_clamp_kind, 0);
      end else begin
        want = pending_bins.pop_front();
        if (out_real !== want.re)
          report("out_real", $signed(out_real), $signed(want.re));
        if (out_imag !== want.im)
          report("out_imag", $signed(out_imag), $signed(want.im));
        if (out_clamp_kind !== want.kind)
          report("out_clamp_kind", out_clamp_kind, want.kind);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("spectral_bin_magnitude_clamp_tb failed");
    $finish;
  end

endmodule
